@@ rtl/gesture_template_matcher_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the gesture template matcher
// Shared property wrappers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef GESTURE_TEMPLATE_MATCHER_ASSERT_SVH
`define GESTURE_TEMPLATE_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/gtm_pkg.sv @@
// ---------------------------------------------------------------------------
// gtm_pkg
// Types, opcodes and sizing constants of the gesture template matcher.
// ---------------------------------------------------------------------------
package gtm_pkg;

   localparam int GTM_NUM_SLOTS  = 8;
   localparam int GTM_MAX_POINTS = 16;
   localparam int COORD_BITS     = 16;

   localparam int OPCODE_BITS = 3;
   localparam int SLOT_BITS   = 3;
   localparam int INDEX_BITS  = 4;
   localparam int TOL_BITS    = 16;
   localparam int MASK_BITS   = 8;

   // Offset from the origin and difference against a template point.
   localparam int OFS_BITS  = COORD_BITS + 1;
   localparam int DIFF_BITS = COORD_BITS + 2;
   localparam int CMP_BITS  = (DIFF_BITS > TOL_BITS) ? DIFF_BITS : TOL_BITS;

   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd50;

   localparam logic [OPCODE_BITS-1:0] OP_START = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_TRACK = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_STOP  = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_LOAD  = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 3'd4;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic signed [15:0]     point_x;
      logic signed [15:0]     point_y;
      logic [SLOT_BITS-1:0]   gesture_slot;
      logic [INDEX_BITS-1:0]  point_index;
      logic                   point_is_last;
   } gtm_req_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] match_mask;
      logic                 points_seen;
   } gtm_rsp_type;

   typedef struct packed {
      logic start;
      logic track;
      logic load;
      logic clear;
      logic last;
   } gtm_slot_cmd_type;

endpackage

@@ rtl/gtm_slot.sv @@
// ---------------------------------------------------------------------------
// gtm_slot
// One template slot: point store, length, validity, match progress and the
// per-axis tolerance compare against the slot's next template point.
// ---------------------------------------------------------------------------
module gtm_slot #(
   parameter int MAX_POINTS = gtm_pkg::GTM_MAX_POINTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gtm_pkg::gtm_slot_cmd_type             cmd,
   input  logic [gtm_pkg::INDEX_BITS-1:0]        wr_index,
   input  logic signed [gtm_pkg::COORD_BITS-1:0] wr_x,
   input  logic signed [gtm_pkg::COORD_BITS-1:0] wr_y,
   input  logic signed [gtm_pkg::OFS_BITS-1:0]   ofs_x,
   input  logic signed [gtm_pkg::OFS_BITS-1:0]   ofs_y,
   input  logic [gtm_pkg::TOL_BITS-1:0]          tolerance,
   output logic                                  done
);
   import gtm_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PW = $clog2(MAX_POINTS + 1);

   logic [2*COORD_BITS-1:0] point_mem [MAX_POINTS];

   logic                    valid_ff, valid_in;
   logic [PW-1:0]           len_ff, len_in;
   logic [PW-1:0]           prog_ff, prog_in;
   logic [2*COORD_BITS-1:0] next_pt_ff;

   logic signed [COORD_BITS-1:0] tx, ty;
   logic signed [DIFF_BITS-1:0]  dx, dy;
   logic [DIFF_BITS-1:0]         mag_x, mag_y;
   logic                         hit;
   logic [AW-1:0]                wr_addr;

   assign tx      = next_pt_ff[2*COORD_BITS-1:COORD_BITS];
   assign ty      = next_pt_ff[COORD_BITS-1:0];
   assign dx      = DIFF_BITS'(tx) - DIFF_BITS'(ofs_x);
   assign dy      = DIFF_BITS'(ty) - DIFF_BITS'(ofs_y);
   assign mag_x   = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
   assign mag_y   = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
   assign hit     = (CMP_BITS'(mag_x) < CMP_BITS'(tolerance)) &&
                    (CMP_BITS'(mag_y) < CMP_BITS'(tolerance));
   assign wr_addr = AW'(wr_index);
   assign done    = valid_ff && (prog_ff == len_ff);

   always_comb begin
      valid_in = valid_ff;
      len_in   = len_ff;
      prog_in  = prog_ff;
      if (cmd.start) begin
         prog_in = '0;
      end
      if (cmd.track && valid_ff && (prog_ff < len_ff) && hit) begin
         prog_in = prog_ff + PW'(1);
      end
      if (cmd.clear) begin
         valid_in = 1'b0;
         len_in   = '0;
      end
      if (cmd.load && cmd.last) begin
         valid_in = 1'b1;
         len_in   = PW'(wr_index) + PW'(1);
      end
   end

   // The point for the next compare is fetched at the progress that the
   // current transfer leaves behind, so it is registered and ready in the next cycle.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         point_mem[wr_addr] <= {wr_x, wr_y};
      end
      next_pt_ff <= point_mem[prog_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         len_ff   <= '0;
         prog_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         len_ff   <= len_in;
         prog_ff  <= prog_in;
      end
   end

endmodule

@@ rtl/gesture_template_matcher.sv @@
// ---------------------------------------------------------------------------
// gesture_template_matcher
// Streams pointer strokes against stored gesture templates, one per slot.
// ---------------------------------------------------------------------------
// Each item is registered on acceptance and executed in the following cycle;
// one item can be taken every cycle, so the block sustains one transfer per
// clock. The only pause is a stop that finds the response register full and
// stalled: it waits in the input register, and the request side stalls, until
// the response is taken. Each slot keeps its template points in a small local
// memory and fetches its next point ahead into a register, so a track point
// is compared in all slots at once. The tolerance must be written only while
// no transfer is in flight.
module gesture_template_matcher #(
   parameter int NUM_SLOTS  = gtm_pkg::GTM_NUM_SLOTS,
   parameter int MAX_POINTS = gtm_pkg::GTM_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gtm_pkg::gtm_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gtm_pkg::gtm_rsp_type          rsp_data,
   input  logic                          csr_wr_en,
   input  logic [gtm_pkg::TOL_BITS-1:0]  csr_wr_data
);
   import gtm_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   gtm_req_type s1_item_ff;
   logic        s1_go, fire, rsp_free;

   logic                         matching_ff, matching_in;
   logic                         tracked_ff, tracked_in;
   logic signed [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic [TOL_BITS-1:0]          tolerance_ff;

   logic rsp_valid_ff, rsp_valid_in;
   gtm_rsp_type rsp_data_ff, rsp_data_in;

   logic is_start, is_track, is_stop, is_load, is_clear;
   logic track_en, load_en, clear_en;
   logic signed [COORD_BITS-1:0] px, py;
   logic signed [OFS_BITS-1:0]   ofs_x, ofs_y;
   logic [NUM_SLOTS-1:0]         done_vec, load_vec;
   logic [MASK_BITS-1:0]         mask_w;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = (s1_item_ff.opcode != OP_STOP) || rsp_free;
   assign fire      = s1_valid_ff && s1_go;
   assign req_stall = s1_valid_ff && !s1_go;

   always_comb begin
      is_start = 1'b0;
      is_track = 1'b0;
      is_stop  = 1'b0;
      is_load  = 1'b0;
      is_clear = 1'b0;
      case (s1_item_ff.opcode)
         OP_START: is_start = fire;
         OP_TRACK: is_track = fire;
         OP_STOP:  is_stop  = fire;
         OP_LOAD:  is_load  = fire;
         OP_CLEAR: is_clear = fire;
         default: ;
      endcase
   end

   // Templates are frozen while matching; out-of-range slots and indexes
   // are dropped.
   assign track_en = is_track && matching_ff;
   assign load_en  = is_load && !matching_ff &&
                     (32'(s1_item_ff.gesture_slot) < NUM_SLOTS) &&
                     (32'(s1_item_ff.point_index) < MAX_POINTS);
   assign clear_en = is_clear && !matching_ff &&
                     (32'(s1_item_ff.gesture_slot) < NUM_SLOTS);

   assign px    = COORD_BITS'(s1_item_ff.point_x);
   assign py    = COORD_BITS'(s1_item_ff.point_y);
   assign ofs_x = OFS_BITS'(px) - OFS_BITS'(origin_x_ff);
   assign ofs_y = OFS_BITS'(py) - OFS_BITS'(origin_y_ff);

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
      gtm_slot_cmd_type cmd;
      logic             sel;

      assign sel         = (32'(s1_item_ff.gesture_slot) == s);
      assign load_vec[s] = load_en && sel;
      assign cmd.start   = is_start;
      assign cmd.track   = track_en;
      assign cmd.load    = load_vec[s];
      assign cmd.clear   = clear_en && sel;
      assign cmd.last    = s1_item_ff.point_is_last;

      gtm_slot #(
         .MAX_POINTS (MAX_POINTS)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .wr_index  (s1_item_ff.point_index),
         .wr_x      (px),
         .wr_y      (py),
         .ofs_x     (ofs_x),
         .ofs_y     (ofs_y),
         .tolerance (tolerance_ff),
         .done      (done_vec[s])
      );
   end

   for (genvar m = 0; m < MASK_BITS; m++) begin : g_mask
      if (m < NUM_SLOTS) begin : g_used
         assign mask_w[m] = done_vec[m];
      end else begin : g_unused
         assign mask_w[m] = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end

      matching_in = matching_ff;
      tracked_in  = tracked_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (is_start) begin
         matching_in = 1'b1;
         tracked_in  = 1'b0;
         origin_x_in = px;
         origin_y_in = py;
      end
      if (track_en) begin
         tracked_in = 1'b1;
      end
      if (is_stop) begin
         matching_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (is_stop) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.match_mask  = matching_ff ? mask_w : '0;
         rsp_data_in.points_seen = matching_ff && tracked_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_data;
      end
      origin_x_ff <= origin_x_in;
      origin_y_ff <= origin_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         matching_ff  <= 1'b0;
         tracked_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tolerance_ff <= TOL_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         matching_ff  <= matching_in;
         tracked_ff   <= tracked_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tolerance_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "gesture_template_matcher_assert.svh"

   // A stop may only execute into a free response register.
   `GTM_ASSERT_SAME(a_stop_has_room, is_stop, rsp_free, "stop executed over a pending response")
   // A stop always ends the match in progress.
   `GTM_ASSERT_NEXT(a_stop_ends_match, is_stop, !matching_ff, "matching still active after stop")
   // At most one slot takes a template point per transfer.
   `GTM_ASSERT_SAME(a_one_load, 1'b1, $onehot0(load_vec), "template point written to several slots")
   // A held item stays put until it can execute.
   `GTM_ASSERT_NEXT(a_hold_item, req_stall, s1_valid_ff && $stable(s1_item_ff), "held item lost")

endmodule

@@ tb/gesture_template_matcher_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gesture template matcher testbench
// Loads stroke templates, replays strokes that follow them with jitter inside
// and outside the tolerance, mixes in random commands, and checks every stop
// result against a cycle-free model of the slots kept in a scoreboard class.
// ---------------------------------------------------------------------------
module gesture_template_matcher_tb;
   import gtm_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int LONG_HOLD    = 80;
   localparam int OPCODE_LAST  = (1 << OPCODE_BITS) - 1;
   localparam int PHASE_ITEMS  = 90;
   localparam int MIN_RESULTS  = 48;

   class stroke_match_scoreboard;
      logic [TOL_BITS-1:0] tolerance;
      int origin_x;
      int origin_y;
      int tpl_x [GTM_NUM_SLOTS][GTM_MAX_POINTS];
      int tpl_y [GTM_NUM_SLOTS][GTM_MAX_POINTS];
      bit point_loaded [GTM_NUM_SLOTS][GTM_MAX_POINTS];
      int length [GTM_NUM_SLOTS];
      bit slot_loaded [GTM_NUM_SLOTS];
      int progress [GTM_NUM_SLOTS];
      bit matching;
      bit tracked;
      gtm_rsp_type expected_masks [$];
      int masks_predicted;
      int mismatches;

      function new();
         int s;
         int p;
         tolerance = TOL_RESET;
         origin_x = 0;
         origin_y = 0;
         for (s = 0; s < GTM_NUM_SLOTS; s++) begin
            length[s] = 0;
            slot_loaded[s] = 1'b0;
            progress[s] = 0;
            for (p = 0; p < GTM_MAX_POINTS; p++) begin
               tpl_x[s][p] = 0;
               tpl_y[s][p] = 0;
               point_loaded[s][p] = 1'b0;
            end
         end
         matching = 1'b0;
         tracked = 1'b0;
         masks_predicted = 0;
         mismatches = 0;
      endfunction

      // Apply one accepted request to the slot state; a stop queues its mask.
      function void predict_item(gtm_req_type item);
         int s;
         int p;
         int ofs_x;
         int ofs_y;
         int dx;
         int dy;
         gtm_rsp_type res;
         case (item.opcode)
            OP_START: begin
               origin_x = $signed(item.point_x);
               origin_y = $signed(item.point_y);
               for (s = 0; s < GTM_NUM_SLOTS; s++) progress[s] = 0;
               matching = 1'b1;
               tracked = 1'b0;
            end
            OP_TRACK: begin
               if (matching) begin
                  ofs_x = $signed(item.point_x);
                  ofs_y = $signed(item.point_y);
                  ofs_x = ofs_x - origin_x;
                  ofs_y = ofs_y - origin_y;
                  for (s = 0; s < GTM_NUM_SLOTS; s++) begin
                     p = progress[s];
                     if (slot_loaded[s] && p < length[s]) begin
                        dx = tpl_x[s][p] - ofs_x;
                        dy = tpl_y[s][p] - ofs_y;
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        if (dx < int'(tolerance) && dy < int'(tolerance))
                           progress[s] = p + 1;
                     end
                  end
                  tracked = 1'b1;
               end
            end
            OP_STOP: begin
               res = '0;
               if (matching) begin
                  for (s = 0; s < GTM_NUM_SLOTS; s++)
                     if (slot_loaded[s] && progress[s] == length[s])
                        res.match_mask[s] = 1'b1;
                  res.points_seen = tracked;
                  matching = 1'b0;
               end
               expected_masks.push_back(res);
               masks_predicted++;
            end
            OP_LOAD: begin
               if (!matching) begin
                  tpl_x[item.gesture_slot][item.point_index] = $signed(item.point_x);
                  tpl_y[item.gesture_slot][item.point_index] = $signed(item.point_y);
                  point_loaded[item.gesture_slot][item.point_index] = 1'b1;
                  if (item.point_is_last) begin
                     length[item.gesture_slot] = item.point_index + 1;
                     slot_loaded[item.gesture_slot] = 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               if (!matching) begin
                  slot_loaded[item.gesture_slot] = 1'b0;
                  length[item.gesture_slot] = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(gtm_rsp_type got);
         gtm_rsp_type want;
         if (expected_masks.size() == 0) begin
            $display("%0t: result with nothing expected, match_mask %h points_seen %b",
                     $time, got.match_mask, got.points_seen);
            mismatches++;
         end else begin
            want = expected_masks.pop_front();
            if (got.match_mask !== want.match_mask) begin
               $display("%0t: match_mask expected %h actual %h",
                        $time, want.match_mask, got.match_mask);
               mismatches++;
            end
            if (got.points_seen !== want.points_seen) begin
               $display("%0t: points_seen expected %b actual %b",
                        $time, want.points_seen, got.points_seen);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   gtm_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   gtm_rsp_type         rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [TOL_BITS-1:0] csr_wr_data = '0;

   stroke_match_scoreboard sb = new();
   bit gaps_on = 1'b1;
   bit hold_request = 1'b0;
   int accepted_items = 0;
   int cycle_count = 0;

   gesture_template_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, 5) : 0;
   endfunction

   function automatic int rand_coord();
      logic signed [15:0] v;
      v = 16'($urandom);
      return int'(v);
   endfunction

   function automatic logic signed [15:0] fit_coord(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic gtm_req_type make_item(logic [OPCODE_BITS-1:0] op, int x, int y,
                                             int slot, int idx, bit last);
      gtm_req_type r;
      r.opcode = op;
      r.point_x = fit_coord(x);
      r.point_y = fit_coord(y);
      r.gesture_slot = slot[SLOT_BITS-1:0];
      r.point_index = idx[INDEX_BITS-1:0];
      r.point_is_last = last;
      return r;
   endfunction

   // Result sink: random back-pressure per result, plus one long hold on request.
   initial begin
      int wait_left;
      int hold_left;
      wait_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0) || (wait_left > 0);
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            sb.check_result(rsp_data);
            wait_left = draw_gap();
         end else if (rsp_valid === 1'b1 && wait_left > 0) begin
            wait_left--;
         end
      end
   end

   task automatic send_item(input gtm_req_type item);
      int gap;
      int i;
      bit complete;
      gap = draw_gap();
      // A last point may only close a template whose earlier points all exist,
      // so that no slot ever compares against an unwritten entry.
      if (item.opcode == OP_LOAD && item.point_is_last && !sb.matching) begin
         complete = 1'b1;
         for (i = 0; i < item.point_index; i++)
            if (!sb.point_loaded[item.gesture_slot][i]) complete = 1'b0;
         if (!complete) item.point_is_last = 1'b0;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.predict_item(item);
      if (item.opcode <= OP_CLEAR) accepted_items++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_masks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.tolerance = value;
   endtask

   task automatic send_noise();
      send_item(make_item(OPCODE_BITS'($urandom_range(0, OPCODE_LAST)), rand_coord(),
                          rand_coord(), $urandom_range(0, 7), $urandom_range(0, 15),
                          1'($urandom_range(0, 1))));
   endtask

   task automatic load_template(input int slot, input int len);
      int i;
      bit wide;
      wide = ($urandom_range(0, 7) == 0);
      for (i = 0; i < len; i++)
         send_item(make_item(OP_LOAD,
                             wide ? rand_coord() : int'($urandom_range(0, 800)) - 400,
                             wide ? rand_coord() : int'($urandom_range(0, 800)) - 400,
                             slot, i, i == len - 1));
   endtask

   // One stroke: optional stop, loads and clear, a start, tracks that follow
   // one loaded template with some jitter and stray points, then usually a stop.
   task automatic run_stroke();
      int n;
      int s;
      int i;
      int target;
      int mag;
      int jx;
      int jy;
      int ox;
      int oy;
      int cands [$];
      if (sb.matching && $urandom_range(0, 3) != 0)
         send_item(make_item(OP_STOP, 0, 0, 0, 0, 0));
      n = $urandom_range(0, 2);
      repeat (n) begin
         s = $urandom_range(0, 7);
         load_template(s, ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 5));
      end
      if ($urandom_range(0, 4) == 0)
         send_item(make_item(OP_CLEAR, 0, 0, $urandom_range(0, 7), 0, 0));
      ox = int'($urandom_range(0, 20000)) - 10000;
      oy = int'($urandom_range(0, 20000)) - 10000;
      send_item(make_item(OP_START, ox, oy, $urandom_range(0, 7), $urandom_range(0, 15),
                          1'($urandom_range(0, 1))));
      for (s = 0; s < GTM_NUM_SLOTS; s++)
         if (sb.slot_loaded[s]) cands.push_back(s);
      if (sb.tolerance == 0) mag = 0;
      else if (int'(sb.tolerance) - 1 < 40) mag = int'(sb.tolerance) - 1;
      else mag = 40;
      if (cands.size() > 0) begin
         target = cands[$urandom_range(0, cands.size() - 1)];
         for (i = 0; i < sb.length[target]; i++) begin
            if ($urandom_range(0, 6) == 0)
               send_item(make_item(OP_TRACK, rand_coord(), rand_coord(), 0, 0, 0));
            jx = int'($urandom_range(0, 2 * mag)) - mag;
            jy = int'($urandom_range(0, 2 * mag)) - mag;
            // Now and then push one axis further out, which can take it outside the window.
            if ($urandom_range(0, 11) == 0) jx = jx + mag + 1 + int'($urandom_range(0, 50));
            send_item(make_item(OP_TRACK, ox + sb.tpl_x[target][i] + jx,
                                oy + sb.tpl_y[target][i] + jy, $urandom_range(0, 7),
                                $urandom_range(0, 15), 1'($urandom_range(0, 1))));
         end
      end else begin
         repeat ($urandom_range(1, 4))
            send_item(make_item(OP_TRACK, rand_coord(), rand_coord(), 0, 0, 0));
      end
      if ($urandom_range(0, 5) != 0)
         send_item(make_item(OP_STOP, 0, 0, 0, 0, 0));
   endtask

   task automatic run_random(input int count, input int result_goal);
      int goal;
      goal = accepted_items + count;
      while (accepted_items < goal || sb.masks_predicted < result_goal) begin
         if ($urandom_range(0, 9) < 7) run_stroke();
         else repeat ($urandom_range(1, 3)) send_noise();
      end
      drain_results();
   endtask

   initial begin
      int op;
      logic [TOL_BITS-1:0] tol_list [5];
      int phase;
      tol_list[0] = '0;
      tol_list[1] = '1;
      tol_list[2] = 16'd1;
      tol_list[3] = 16'($urandom_range(2, 65534));
      tol_list[4] = 16'd300;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset tolerance.
      send_item(make_item(OP_STOP, 0, 0, 0, 0, 0));
      send_item(make_item(OP_TRACK, 5, 5, 0, 0, 0));
      for (op = OP_CLEAR + 1; op <= OPCODE_LAST; op++)
         send_item(make_item(OPCODE_BITS'(op), rand_coord(), rand_coord(),
                             $urandom_range(0, 7), $urandom_range(0, 15), 1'b1));
      send_item(make_item(OP_LOAD, 10, -10, 0, 0, 1'b0));
      send_item(make_item(OP_LOAD, 20, -20, 0, 1, 1'b1));
      send_item(make_item(OP_LOAD, 32767, -32768, 7, 0, 1'b1));
      send_item(make_item(OP_LOAD, 0, 0, 5, 0, 1'b1));
      send_item(make_item(OP_CLEAR, 0, 0, 5, 0, 1'b0));
      send_item(make_item(OP_START, 100, 100, 0, 0, 1'b0));
      send_item(make_item(OP_LOAD, 1, 1, 1, 0, 1'b1));
      send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 1'b0));
      send_item(make_item(OP_TRACK, 110, 90, 0, 0, 1'b0));
      send_item(make_item(OP_START, 0, 0, 0, 0, 1'b0));
      send_item(make_item(OP_TRACK, 10, -10, 0, 0, 1'b0));
      send_item(make_item(OP_TRACK, 20, -20, 0, 0, 1'b0));
      send_item(make_item(OP_TRACK, 32767, -32768, 0, 0, 1'b0));
      send_item(make_item(OP_STOP, 0, 0, 0, 0, 1'b0));
      send_item(make_item(OP_START, -32768, -32768, 7, 15, 1'b1));
      send_item(make_item(OP_TRACK, 32767, 32767, 7, 15, 1'b1));
      send_item(make_item(OP_STOP, 0, 0, 7, 15, 1'b1));
      send_item(make_item(OP_START, 5, 5, 0, 0, 1'b0));
      send_item(make_item(OP_STOP, 0, 0, 0, 0, 1'b0));
      drain_results();

      // Hold the result side so that stops pile up and the request side stalls.
      gaps_on = 1'b0;
      hold_request = 1'b1;
      send_item(make_item(OP_START, 0, 0, 0, 0, 1'b0));
      repeat (6) begin
         send_item(make_item(OP_TRACK, 10, -10, 0, 0, 1'b0));
         send_item(make_item(OP_STOP, 0, 0, 0, 0, 1'b0));
         send_item(make_item(OP_START, 0, 0, 0, 0, 1'b0));
      end
      send_item(make_item(OP_STOP, 0, 0, 0, 0, 1'b0));
      drain_results();
      gaps_on = 1'b1;

      run_random(PHASE_ITEMS, 0);
      for (phase = 0; phase < 5; phase++) begin
         gaps_on = (phase != 2);
         write_tolerance(tol_list[phase]);
         run_random(PHASE_ITEMS / 2, (phase == 4) ? MIN_RESULTS : 0);
      end
      gaps_on = 1'b1;
      write_tolerance(TOL_RESET);
      run_random(PHASE_ITEMS, MIN_RESULTS);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_masks.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
